// ----- hdl/bfnb_pkg.sv -----
// ----------------------------------------------------------------------------
// bfnb_pkg
// Shared types, constants and helpers for the bitmap find-next-bit unit.
// ----------------------------------------------------------------------------
package bfnb_pkg;

   localparam int TOTAL_BITS  = 4096;
   localparam int WORD_BITS   = 64;
   localparam int NWORDS      = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int CAPACITY    = NWORDS * WORD_BITS;
   localparam int WORD_ADDR_W = $clog2(NWORDS);
   localparam int BIT_OFS_W   = $clog2(WORD_BITS);

   // item field widths
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 12;
   localparam int END_W   = 13;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FILL_VALUE_ADDR = CSR_ADDR_W'(0);

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_FIND  = 2'd2,
      MODE_FILL  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef logic [WORD_BITS-1:0]   word_type;
   typedef logic [WORD_ADDR_W-1:0] waddr_type;
   typedef logic [BIT_OFS_W-1:0]   bofs_type;

   // index of lowest set bit; isolate it, then OR-encode
   function automatic bofs_type lowest_set(input word_type w);
      word_type onehot;
      bofs_type pos;
      onehot = w & (~w + word_type'(1));
      pos    = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (onehot[i]) pos = pos | BIT_OFS_W'(i);
      end
      return pos;
   endfunction

endpackage

// ----- hdl/bfnb_req_if.sv -----
// ----------------------------------------------------------------------------
// bfnb_req_if
// Request channel: valid/ready handshake with the operation item.
// ----------------------------------------------------------------------------
interface bfnb_req_if;
   logic                            valid;
   logic                            ready;
   logic [bfnb_pkg::MODE_W-1:0]     mode;
   logic [bfnb_pkg::INDEX_W-1:0]    bit_index;
   logic [bfnb_pkg::END_W-1:0]      end_index;
   logic                            bit_value;

   modport source (output valid, mode, bit_index, end_index, bit_value, input ready);
   modport sink   (input valid, mode, bit_index, end_index, bit_value, output ready);
endinterface

// ----- hdl/bfnb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bfnb_rsp_if
// Response channel: valid/ready handshake with the result item.
// ----------------------------------------------------------------------------
interface bfnb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [bfnb_pkg::INDEX_W-1:0]    position;
   logic                            read_bit;
   logic                            range_error;

   modport source (output valid, found, position, read_bit, range_error, input ready);
   modport sink   (input valid, found, position, read_bit, range_error, output ready);
endinterface

// ----- hdl/bfnb_ram.sv -----
// ----------------------------------------------------------------------------
// bfnb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfnb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bitmap_find_next_bit_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_find_next_bit_unit
// Bit store of 64-bit words in RAM with read, write, find-next and fill ops.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_ch    in         valid/ready        mode, bit_index, end_index, bit_value
//  rsp_ch    out        valid/ready        found, position, read_bit, range_error
//  csr_*     in         APB write/read     fill_value at byte address 0
//
//  One item at a time. Read/write: RAM read, modify/write back, then the result
//  into the output register. Find: one RAM word per cycle over the 64-word
//  store, then the result. Fill: done by clearing per-word valid flags, so no
//  reset sweep is needed.
//  A held result in the output register does not block the next item; only the
//  result hand-off waits on rsp ready.
// ----------------------------------------------------------------------------
module bitmap_find_next_bit_unit (
   input  logic                                clock,
   input  logic                                reset,
   bfnb_req_if.sink                            req_ch,
   bfnb_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bfnb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bfnb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bfnb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   bfnb_pkg::state_type                  state_ff, state_in;
   bfnb_pkg::mode_type                   mode_ff, mode_in;
   bfnb_pkg::bofs_type                   ofs_ff, ofs_in;
   bfnb_pkg::waddr_type                  cur_ff, cur_in;
   bfnb_pkg::waddr_type                  first_ff, first_in;
   bfnb_pkg::waddr_type                  last_ff, last_in;
   logic [bfnb_pkg::END_W-1:0]           end_ff, end_in;
   logic                                 val_ff, val_in;
   logic [bfnb_pkg::NWORDS-1:0]          valid_ff, valid_in;
   logic                                 fill_bit_ff, fill_bit_in;
   logic                                 fill_value_ff;

   logic                                 res_found_ff, res_found_in;
   logic [bfnb_pkg::INDEX_W-1:0]         res_pos_ff, res_pos_in;
   logic                                 res_rbit_ff, res_rbit_in;
   logic                                 res_rerr_ff, res_rerr_in;

   logic                                 out_valid_ff;
   logic                                 out_found_ff;
   logic [bfnb_pkg::INDEX_W-1:0]         out_pos_ff;
   logic                                 out_rbit_ff;
   logic                                 out_rerr_ff;
   logic                                 out_load;

   logic                                 mem_we;
   bfnb_pkg::waddr_type                  mem_waddr;
   bfnb_pkg::word_type                   mem_wdata;
   bfnb_pkg::waddr_type                  mem_raddr;
   bfnb_pkg::word_type                   mem_rdata;

   bfnb_pkg::word_type                   raw_word;
   bfnb_pkg::word_type                   cand_word;
   logic [bfnb_pkg::INDEX_W-1:0]         cand_pos;
   logic                                 req_accept;
   logic                                 csr_write;

   bfnb_ram #(
      .WIDTH (bfnb_pkg::WORD_BITS),
      .DEPTH (bfnb_pkg::NWORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == bfnb_pkg::CSR_FILL_VALUE_ADDR) begin
         csr_prdata = bfnb_pkg::CSR_DATA_W'(fill_value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_value_ff <= 1'b0;
      end else if (csr_write && (csr_paddr == bfnb_pkg::CSR_FILL_VALUE_ADDR)) begin
         fill_value_ff <= csr_pwdata[0];
      end
   end

   // ---------------- word view ----------------
   // words not written since the last fill read as the fill pattern
   always_comb begin
      raw_word = valid_ff[cur_ff] ? mem_rdata : {bfnb_pkg::WORD_BITS{fill_bit_ff}};
      cand_word = val_ff ? raw_word : ~raw_word;
      if (cur_ff == first_ff) begin
         cand_word = cand_word & ({bfnb_pkg::WORD_BITS{1'b1}} << ofs_ff);
      end
      cand_pos = {cur_ff, bfnb_pkg::lowest_set(cand_word)};
   end

   // ready is high exactly in idle
   assign req_accept = req_ch.valid && (state_ff == bfnb_pkg::ST_IDLE);
   assign out_load   = (state_ff == bfnb_pkg::ST_RESP) && (!out_valid_ff || rsp_ch.ready);

   // ---------------- control ----------------
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ofs_in       = ofs_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      val_in       = val_ff;
      valid_in     = valid_ff;
      fill_bit_in  = fill_bit_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      res_rbit_in  = res_rbit_ff;
      res_rerr_in  = res_rerr_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = raw_word;
      mem_raddr    = cur_ff;
      req_ch.ready = 1'b0;

      case (state_ff)
         bfnb_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            mem_raddr    = req_ch.bit_index[bfnb_pkg::INDEX_W-1:bfnb_pkg::BIT_OFS_W];
            if (req_accept) begin
               mode_in      = bfnb_pkg::mode_type'(req_ch.mode);
               ofs_in       = req_ch.bit_index[bfnb_pkg::BIT_OFS_W-1:0];
               cur_in       = req_ch.bit_index[bfnb_pkg::INDEX_W-1:bfnb_pkg::BIT_OFS_W];
               first_in     = req_ch.bit_index[bfnb_pkg::INDEX_W-1:bfnb_pkg::BIT_OFS_W];
               val_in       = req_ch.bit_value;
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_rbit_in  = 1'b0;
               res_rerr_in  = 1'b0;
               // clamp end to capacity
               if (req_ch.end_index > bfnb_pkg::END_W'(bfnb_pkg::CAPACITY)) begin
                  end_in = bfnb_pkg::END_W'(bfnb_pkg::CAPACITY);
               end else begin
                  end_in = req_ch.end_index;
               end
               last_in = bfnb_pkg::WORD_ADDR_W'((end_in - bfnb_pkg::END_W'(1))
                                                >> bfnb_pkg::BIT_OFS_W);
               case (bfnb_pkg::mode_type'(req_ch.mode))
                  bfnb_pkg::MODE_READ, bfnb_pkg::MODE_WRITE: begin
                     if ({1'b0, req_ch.bit_index} >= bfnb_pkg::END_W'(bfnb_pkg::CAPACITY)) begin
                        res_rerr_in = 1'b1;
                        state_in    = bfnb_pkg::ST_RESP;
                     end else begin
                        state_in = bfnb_pkg::ST_ACCESS;
                     end
                  end
                  bfnb_pkg::MODE_FIND: begin
                     if (req_ch.end_index <= {1'b0, req_ch.bit_index}) begin
                        state_in = bfnb_pkg::ST_RESP;
                     end else if ({1'b0, req_ch.bit_index} >=
                                  bfnb_pkg::END_W'(bfnb_pkg::CAPACITY)) begin
                        res_rerr_in = 1'b1;
                        state_in    = bfnb_pkg::ST_RESP;
                     end else begin
                        state_in = bfnb_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     valid_in    = '0;
                     fill_bit_in = fill_value_ff;
                     state_in    = bfnb_pkg::ST_RESP;
                  end
               endcase
            end
         end

         bfnb_pkg::ST_ACCESS: begin
            if (mode_ff == bfnb_pkg::MODE_READ) begin
               res_rbit_in = raw_word[ofs_ff];
            end else begin
               mem_we            = 1'b1;
               mem_wdata         = raw_word;
               mem_wdata[ofs_ff] = val_ff;
               valid_in[cur_ff]  = 1'b1;
            end
            state_in = bfnb_pkg::ST_RESP;
         end

         bfnb_pkg::ST_SCAN: begin
            // fetch the next word while this one is examined
            mem_raddr = cur_ff + bfnb_pkg::WORD_ADDR_W'(1);
            if (cand_word != '0) begin
               if ({1'b0, cand_pos} < end_ff) begin
                  res_found_in = 1'b1;
                  res_pos_in   = cand_pos;
               end
               state_in = bfnb_pkg::ST_RESP;
            end else if (cur_ff == last_ff) begin
               state_in = bfnb_pkg::ST_RESP;
            end else begin
               cur_in = cur_ff + bfnb_pkg::WORD_ADDR_W'(1);
            end
         end

         bfnb_pkg::ST_RESP: begin
            if (out_load) begin
               state_in = bfnb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bfnb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bfnb_pkg::ST_IDLE;
         valid_ff    <= '0;
         fill_bit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         fill_bit_ff <= fill_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      ofs_ff       <= ofs_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      end_ff       <= end_in;
      val_ff       <= val_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_rbit_ff  <= res_rbit_in;
      res_rerr_ff  <= res_rerr_in;
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_found_ff <= res_found_ff;
         out_pos_ff   <= res_pos_ff;
         out_rbit_ff  <= res_rbit_ff;
         out_rerr_ff  <= res_rerr_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.found       = out_found_ff;
   assign rsp_ch.position    = out_pos_ff;
   assign rsp_ch.read_bit    = out_rbit_ff;
   assign rsp_ch.range_error = out_rerr_ff;

endmodule

// ----- hdl/bfnb_checker.sv -----
// ----------------------------------------------------------------------------
// bfnb_checker
// Port-level checks for the bitmap find-next-bit unit, bound to the top level.
// ----------------------------------------------------------------------------
module bfnb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [bfnb_pkg::INDEX_W-1:0]  rsp_position,
   input logic                          rsp_read_bit,
   input logic                          rsp_range_error
);

   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // one item in flight: after an accept the unit is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in flight");

   a_found_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> !rsp_range_error && !rsp_read_bit)
      else $error("found set together with range error or read bit");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("position nonzero without a match");

endmodule

bind bitmap_find_next_bit_unit bfnb_checker u_bfnb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_found       (rsp_ch.found),
   .rsp_position    (rsp_ch.position),
   .rsp_read_bit    (rsp_ch.read_bit),
   .rsp_range_error (rsp_ch.range_error)
);
